@@ rtl/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg
// Constants, register codes and saturation helpers for the remote setpoint
// shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  localparam int FRAC_BITS = 24;

  // wide signed working width for setpoint arithmetic
  localparam int CALC_W = 42;

  typedef logic signed [CALC_W-1:0] calc_t;

  localparam calc_t LEG_BEGIN = calc_t'(((64'd14 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam calc_t LEG_INIT  = calc_t'(((64'd18 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam calc_t LEG_WIN   = calc_t'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam calc_t LEG_MAX   = calc_t'(((64'd35 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam calc_t V_THRESH  = calc_t'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam calc_t S40_MAX = calc_t'(64'sd549755813887);
  localparam calc_t S40_MIN = -calc_t'(64'sd549755813888);

  // three-position switch codes
  localparam logic [1:0] SW_UP     = 2'd1;
  localparam logic [1:0] SW_DOWN   = 2'd2;
  localparam logic [1:0] SW_MIDDLE = 2'd3;

  // register indexes
  localparam logic [2:0] REG_TURN_GAIN       = 3'd0;
  localparam logic [2:0] REG_LEG_GAIN        = 3'd1;
  localparam logic [2:0] REG_SPEED_GAIN      = 3'd2;
  localparam logic [2:0] REG_RAMP_STEP       = 3'd3;
  localparam logic [2:0] REG_SPEED_LIMIT     = 3'd4;
  localparam logic [2:0] REG_TURN_WINDOW     = 3'd5;
  localparam logic [2:0] REG_POSITION_WINDOW = 3'd6;

  function automatic calc_t clamp(input calc_t v, input calc_t lo, input calc_t hi);
    calc_t r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input calc_t v);
    calc_t r;
    r = clamp(v, S40_MIN, S40_MAX);
    return r[39:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/remote_setpoint_shaper.sv @@
// ----------------------------------------------------------------------------
// remote_setpoint_shaper
// Turns one remote-control word into turn, speed, position and leg setpoints.
// ----------------------------------------------------------------------------
// path from input acceptance to result valid: input register, then result register
// throughput: one word per cycle while the result stream is not stalled, the
// setpoint update is a single pass between the input register and the result register
// reset: control flags clear, setpoints zero, leg setpoint 0.14 m, gains and
// limits load their default values
`default_nettype none

module remote_setpoint_shaper (
  input  wire logic         clk,
  input  wire logic         rst,
  // config port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // turn_stick, speed_stick, leg_wheel, run_switch, leg_switch,
  // measured_yaw, measured_position, left_leg_length, right_leg_length
  input  wire logic [167:0] s_tdata,
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // running, turn_target, speed_target, position_target, leg_target
  output logic      [135:0] m_tdata
);

  // config registers
  logic [15:0] turn_gain;
  logic [15:0] leg_gain;
  logic [15:0] speed_gain;
  logic [23:0] ramp_step;
  logic [25:0] speed_limit;
  logic [25:0] turn_window;
  logic [25:0] position_window;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_gain       <= 16'd1007;
      leg_gain        <= 16'd839;
      speed_gain      <= 16'd15252;
      ramp_step       <= 24'd167772;
      speed_limit     <= 26'd10066330;
      turn_window     <= 26'd5033165;
      position_window <= 26'd838861;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        rss_pkg::REG_TURN_GAIN:       turn_gain       <= pwdata[15:0];
        rss_pkg::REG_LEG_GAIN:        leg_gain        <= pwdata[15:0];
        rss_pkg::REG_SPEED_GAIN:      speed_gain      <= pwdata[15:0];
        rss_pkg::REG_RAMP_STEP:       ramp_step       <= pwdata[23:0];
        rss_pkg::REG_SPEED_LIMIT:     speed_limit     <= pwdata[25:0];
        rss_pkg::REG_TURN_WINDOW:     turn_window     <= pwdata[25:0];
        rss_pkg::REG_POSITION_WINDOW: position_window <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      rss_pkg::REG_TURN_GAIN:       prdata = {16'd0, turn_gain};
      rss_pkg::REG_LEG_GAIN:        prdata = {16'd0, leg_gain};
      rss_pkg::REG_SPEED_GAIN:      prdata = {16'd0, speed_gain};
      rss_pkg::REG_RAMP_STEP:       prdata = {8'd0, ramp_step};
      rss_pkg::REG_SPEED_LIMIT:     prdata = {6'd0, speed_limit};
      rss_pkg::REG_TURN_WINDOW:     prdata = {6'd0, turn_window};
      rss_pkg::REG_POSITION_WINDOW: prdata = {6'd0, position_window};
      default:                      prdata = 32'd0;
    endcase
  end

  // input register and flow control
  logic         in_valid;
  logic [167:0] in_data;
  logic         advance;

  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready & s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  // field unpack
  logic signed [10:0] turn_stick;
  logic signed [10:0] speed_stick;
  logic signed [10:0] leg_wheel;
  logic        [1:0]  run_switch;
  logic        [1:0]  leg_switch;
  logic signed [39:0] measured_yaw;
  logic signed [39:0] measured_position;
  logic        [23:0] left_leg_length;
  logic        [23:0] right_leg_length;

  assign turn_stick        = $signed(in_data[10:0]);
  assign speed_stick       = $signed(in_data[21:11]);
  assign leg_wheel         = $signed(in_data[32:22]);
  assign run_switch        = in_data[34:33];
  assign leg_switch        = in_data[36:35];
  assign measured_yaw      = $signed(in_data[76:37]);
  assign measured_position = $signed(in_data[116:77]);
  assign left_leg_length   = in_data[140:117];
  assign right_leg_length  = in_data[164:141];

  // state
  logic               run_flag;
  logic               leg_arm_flag;
  logic signed [39:0] leg_offset_acc;
  logic signed [39:0] turn_reg;
  logic signed [26:0] speed_reg;
  logic signed [39:0] position_reg;
  logic        [23:0] leg_reg;

  logic               run_flag_next;
  logic               leg_arm_flag_next;
  logic signed [39:0] leg_offset_acc_next;
  logic signed [39:0] turn_reg_next;
  logic signed [26:0] speed_reg_next;
  logic signed [39:0] position_reg_next;
  logic        [23:0] leg_reg_next;

  // products
  logic signed [27:0] wheel_prod;
  logic signed [27:0] turn_prod;
  logic signed [27:0] speed_cmd;

  assign wheel_prod = 28'(leg_wheel) * 28'($signed({1'b0, leg_gain}));
  assign turn_prod  = 28'(turn_stick) * 28'($signed({1'b0, turn_gain}));
  assign speed_cmd  = 28'(speed_stick) * 28'($signed({1'b0, speed_gain}));

  logic signed [39:0] acc_sat;
  logic               arm_set;
  logic signed [39:0] turn_base;
  logic signed [39:0] pos_base;

  assign acc_sat = rss_pkg::sat40(rss_pkg::calc_t'(leg_offset_acc) +
                                  rss_pkg::calc_t'(wheel_prod));

  always_comb begin
    run_flag_next = run_flag;
    turn_base     = turn_reg;
    pos_base      = position_reg;
    if (run_switch == rss_pkg::SW_MIDDLE) begin
      run_flag_next = 1'b1;
    end else if (run_switch == rss_pkg::SW_DOWN) begin
      run_flag_next = 1'b0;
      turn_base     = measured_yaw;
      pos_base      = measured_position;
    end
  end

  assign arm_set = leg_arm_flag | (~run_flag & run_flag_next);

  // speed ramp
  logic signed [28:0] speed_diff;
  logic signed [28:0] speed_diff_abs;
  logic signed [27:0] speed_cmd_abs;
  logic signed [28:0] ramp_s;

  assign speed_diff     = 29'(speed_cmd) - 29'(speed_reg);
  assign speed_diff_abs = (speed_diff < 0) ? -speed_diff : speed_diff;
  assign speed_cmd_abs  = (speed_cmd < 0) ? -speed_cmd : speed_cmd;
  assign ramp_s         = $signed({5'd0, ramp_step});

  rss_pkg::calc_t     leg_pre;
  rss_pkg::calc_t     turn_pre;
  rss_pkg::calc_t     pos_pre;
  logic signed [27:0] speed_pre;

  always_comb begin
    leg_pre             = rss_pkg::calc_t'($signed({1'b0, leg_reg}));
    turn_pre            = rss_pkg::calc_t'(turn_base);
    pos_pre             = rss_pkg::calc_t'(pos_base);
    speed_pre           = 28'(speed_reg);
    leg_offset_acc_next = acc_sat;
    leg_arm_flag_next   = arm_set;
    if (run_flag_next) begin
      leg_pre = rss_pkg::LEG_BEGIN;
      if (leg_switch == rss_pkg::SW_MIDDLE) begin
        if (!arm_set) begin
          leg_pre             = rss_pkg::LEG_INIT + rss_pkg::calc_t'(acc_sat);
          leg_offset_acc_next = '0;
        end
      end else if (leg_switch == rss_pkg::SW_DOWN) begin
        leg_arm_flag_next = 1'b0;
      end
      turn_pre = rss_pkg::calc_t'(turn_base) - rss_pkg::calc_t'(turn_prod);
      if (speed_diff_abs < ramp_s) begin
        speed_pre = speed_cmd;
      end else if (speed_cmd > 28'(speed_reg)) begin
        speed_pre = 28'(speed_reg) + 28'(ramp_s);
      end else begin
        speed_pre = 28'(speed_reg) - 28'(ramp_s);
      end
      if (rss_pkg::calc_t'(speed_cmd_abs) > rss_pkg::V_THRESH) begin
        pos_pre = rss_pkg::calc_t'(measured_position);
      end
    end
  end

  // window and limit clamps
  logic        [24:0] leg_sum;
  rss_pkg::calc_t     leg_len;
  rss_pkg::calc_t     leg_win;
  rss_pkg::calc_t     leg_lim;
  rss_pkg::calc_t     pos_w;
  rss_pkg::calc_t     turn_w;
  rss_pkg::calc_t     pos_ctr;
  rss_pkg::calc_t     yaw_ctr;
  rss_pkg::calc_t     pos_win_s;
  rss_pkg::calc_t     turn_win_s;
  logic signed [27:0] speed_lim_s;

  assign leg_sum    = {1'b0, left_leg_length} + {1'b0, right_leg_length};
  assign leg_len    = rss_pkg::calc_t'($signed({1'b0, leg_sum[24:1]}));
  assign leg_win    = rss_pkg::clamp(leg_pre, leg_len - rss_pkg::LEG_WIN,
                                     leg_len + rss_pkg::LEG_WIN);
  assign leg_lim    = rss_pkg::clamp(leg_win, rss_pkg::LEG_BEGIN, rss_pkg::LEG_MAX);
  assign leg_reg_next = leg_lim[23:0];

  assign pos_ctr    = rss_pkg::calc_t'(measured_position);
  assign pos_win_s  = rss_pkg::calc_t'($signed({1'b0, position_window}));
  assign pos_w      = rss_pkg::clamp(pos_pre, pos_ctr - pos_win_s, pos_ctr + pos_win_s);
  assign position_reg_next = rss_pkg::sat40(pos_w);

  assign yaw_ctr    = rss_pkg::calc_t'(measured_yaw);
  assign turn_win_s = rss_pkg::calc_t'($signed({1'b0, turn_window}));
  assign turn_w     = rss_pkg::clamp(turn_pre, yaw_ctr - turn_win_s, yaw_ctr + turn_win_s);
  assign turn_reg_next = rss_pkg::sat40(turn_w);

  assign speed_lim_s = $signed({2'b0, speed_limit});

  always_comb begin
    speed_reg_next = speed_pre[26:0];
    if (speed_pre > speed_lim_s) begin
      speed_reg_next = speed_lim_s[26:0];
    end else if (speed_pre < -speed_lim_s) begin
      speed_reg_next = 27'(-speed_lim_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag       <= 1'b0;
      leg_arm_flag   <= 1'b0;
      leg_offset_acc <= '0;
      turn_reg       <= '0;
      speed_reg      <= '0;
      position_reg   <= '0;
      leg_reg        <= rss_pkg::LEG_BEGIN[23:0];
    end else if (advance) begin
      run_flag       <= run_flag_next;
      leg_arm_flag   <= leg_arm_flag_next;
      leg_offset_acc <= leg_offset_acc_next;
      turn_reg       <= turn_reg_next;
      speed_reg      <= speed_reg_next;
      position_reg   <= position_reg_next;
      leg_reg        <= leg_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, leg_reg_next, position_reg_next, speed_reg_next,
                  turn_reg_next, run_flag_next};
    end
  end

  // checks
  a_leg_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[131:108] >= rss_pkg::LEG_BEGIN[23:0]) &&
                 (m_tdata[131:108] <= rss_pkg::LEG_MAX[23:0]))
    else $error("leg target outside limits");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (28'($signed(m_tdata[67:41])) <= speed_lim_s) &&
                 (28'($signed(m_tdata[67:41])) >= -speed_lim_s))
    else $error("speed target outside limit");

  a_running_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> (m_tdata[0] == run_flag))
    else $error("running bit differs from run flag");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_data)))
    else $error("pending input word lost");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(leg_offset_acc) && $stable(turn_reg) && $stable(speed_reg)))
    else $error("state changed without a word");

endmodule

`default_nettype wire
